// ===== design/idr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types, register indexes and lookup functions for the index/data
// register file and its memory route decoder.
// ----------------------------------------------------------------------------
package idr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ROUTE_BOARD = 2'd0,
    ROUTE_IO    = 2'd1,
    ROUTE_NONE  = 2'd2
  } route_t;

  localparam logic [7:0] IDX_ID0      = 8'h04;
  localparam logic [7:0] IDX_ID0_B    = 8'h05;
  localparam logic [7:0] IDX_ID0_C    = 8'h06;
  localparam logic [7:0] IDX_ID1      = 8'h08;
  localparam logic [7:0] IDX_LOW_LAST = 8'h13;
  localparam logic [7:0] IDX_HI_FIRST = 8'h28;
  localparam logic [7:0] IDX_HI_LAST  = 8'h2A;

  localparam logic [7:0] ID0_MASK   = ~8'hE3;
  localparam logic [7:0] ID1_MASK   = ~8'hE0;
  localparam logic [7:0] READ_EMPTY = 8'hFF;

  // Stored slots: 0x04-0x06, 0x08-0x13, 0x28-0x2A.
  localparam int NUM_SLOTS  = 18;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_R09   = 4;
  localparam int SLOT_R0A   = 5;
  localparam int SLOT_R0E   = 9;
  localparam int SLOT_LOW   = 3;
  localparam int SLOT_HI    = 15;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_t;

  typedef struct packed {
    logic [7:0]      seg_ctl;
    logic [3:0][7:0] low_map;
    logic [1:0][7:0] high_map;
  } map_regs_t;

  function automatic slot_t slot_lookup(input logic [7:0] idx);
    slot_t      s;
    logic [7:0] off;
    s   = '0;
    off = '0;
    if (idx >= IDX_ID0 && idx <= IDX_ID0_C) begin
      off    = idx - IDX_ID0;
      s.hit  = 1'b1;
      s.slot = SLOT_W'(off);
    end else if (idx >= IDX_ID1 && idx <= IDX_LOW_LAST) begin
      off    = idx - IDX_ID1 + 8'(SLOT_LOW);
      s.hit  = 1'b1;
      s.slot = SLOT_W'(off);
    end else if (idx >= IDX_HI_FIRST && idx <= IDX_HI_LAST) begin
      off    = idx - IDX_HI_FIRST + 8'(SLOT_HI);
      s.hit  = 1'b1;
      s.slot = SLOT_W'(off);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/idr_route.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idr_route
// Memory route decoder: maps a physical address and direction to system
// board, I/O channel or not decoded, from the block bitmaps and segment bits.
// ----------------------------------------------------------------------------
module idr_route
  import idr_pkg::*;
(
  input  var map_regs_t   regs,
  input  wire logic [19:0] address,
  input  wire logic        access_write,
  output route_t           route
);

  logic [4:0] low_blk;
  logic [3:0] high_blk;
  logic [1:0] seg;
  logic [2:0] seg_bit;
  logic       low_hit;
  logic       high_hit;

  assign low_blk  = {address[19], address[17:14]};
  assign high_blk = address[17:14];
  assign seg      = high_blk[3:2];
  assign seg_bit  = access_write ? {1'b1, ~seg} : {1'b0, ~seg};
  assign low_hit  = regs.low_map[low_blk[4:3]][low_blk[2:0]];
  assign high_hit = regs.high_map[high_blk[3]][high_blk[2:0]];

  always_comb begin
    case (address[19:18])
      2'b00: route = ROUTE_NONE;
      2'b01,
      2'b10: route = low_hit ? ROUTE_IO : ROUTE_BOARD;
      default: begin
        if (high_hit || regs.seg_ctl[seg_bit]) begin
          route = ROUTE_IO;
        end else begin
          route = ROUTE_BOARD;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/index_data_regs_with_shadow_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A beat accepted on start is held in the input registers; its result strobe comes from the result register.
// Throughput: one beat per cycle; busy is never raised, one input register
// and one result register bound the single decode pass.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears the index and all stored registers, so routing is defined at once.
// ----------------------------------------------------------------------------
// index_data_regs_with_shadow_decode
// Index/data register file with ID masking and a shadow memory route decoder.
// ----------------------------------------------------------------------------
module index_data_regs_with_shadow_decode
  import idr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic        in_port_odd,
  input  wire logic [7:0]  in_data,
  input  wire logic [19:0] in_address,
  input  wire logic        in_access_write,
  output logic             out_valid,
  output logic [7:0]       out_read_data,
  output logic [1:0]       out_route
);

  logic        in_vld_r;
  logic [1:0]  op_r;
  logic        odd_r;
  logic [7:0]  data_r;
  logic [19:0] addr_r;
  logic        wr_r;

  logic [7:0]  index_r;
  logic [7:0]  regs_r [NUM_SLOTS];

  logic        out_vld_r;
  logic [7:0]  rdata_r;
  logic [1:0]  route_r;
  logic [7:0]  rdata_nxt;
  logic [1:0]  route_nxt;

  slot_t       sel;
  logic [7:0]  sel_val;
  map_regs_t   map_regs;
  route_t      route_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= in_op;
      odd_r  <= in_port_odd;
      data_r <= in_data;
      addr_r <= in_address;
      wr_r   <= in_access_write;
    end
  end

  assign sel     = slot_lookup(index_r);
  assign sel_val = regs_r[sel.slot];

  always_comb begin
    map_regs.seg_ctl = regs_r[SLOT_R09];
    for (int i = 0; i < 4; i++) begin
      map_regs.low_map[i] = regs_r[SLOT_R0A + i];
    end
    for (int i = 0; i < 2; i++) begin
      map_regs.high_map[i] = regs_r[SLOT_R0E + i];
    end
  end

  idr_route u_route (
    .regs         (map_regs),
    .address      (addr_r),
    .access_write (wr_r),
    .route        (route_q)
  );

  always_comb begin
    rdata_nxt = '0;
    route_nxt = '0;
    case (op_t'(op_r))
      OP_READ: begin
        if (!odd_r || !sel.hit) begin
          rdata_nxt = READ_EMPTY;
        end else if (index_r == IDX_ID0) begin
          rdata_nxt = sel_val & ID0_MASK;
        end else if (index_r == IDX_ID1) begin
          rdata_nxt = sel_val & ID1_MASK;
        end else begin
          rdata_nxt = sel_val;
        end
      end
      OP_QUERY: route_nxt = route_q;
      default: begin
        rdata_nxt = '0;
        route_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (in_vld_r && op_t'(op_r) == OP_WRITE) begin
      if (!odd_r) begin
        index_r <= data_r;
      end else if (sel.hit) begin
        regs_r[sel.slot] <= data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      rdata_r <= rdata_nxt;
      route_r <= route_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = rdata_r;
  assign out_route     = route_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives index, data, read and route-query beats into the index/data register
// file with random start gaps, predicts every answer from a local copy of the
// index and the 256-byte register file, and checks each result strobe in order.
// ----------------------------------------------------------------------------
module testbench;
  import idr_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [7:0] RIDX_SEG_CTL  = 8'h09;
  localparam logic [7:0] RIDX_LOW_MAP  = 8'h0A;
  localparam logic [7:0] RIDX_HIGH_MAP = 8'h0E;
  localparam int         NUM_BEATS     = 1250;
  localparam int         TAIL_BEATS    = 150;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic        port_odd;
    logic [7:0]  data;
    logic [19:0] address;
    logic        access_write;
  } beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    route_t     route;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic        in_port_odd = 1'b0;
  logic [7:0]  in_data = '0;
  logic [19:0] in_address = '0;
  logic        in_access_write = 1'b0;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic [1:0]  out_route;

  beat_t   pending_beats[$];
  answer_t expected_answers[$];
  beat_t   cur_beat;
  int      gap_left = 0;
  int      launched = 0;
  int      errors = 0;
  int      cycles = 0;

  logic [7:0] model_index;
  logic [7:0] model_regs[256];

  index_data_regs_with_shadow_decode u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_port_odd    (in_port_odd),
    .in_data        (in_data),
    .in_address     (in_address),
    .in_access_write(in_access_write),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_route      (out_route)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] port_value(input logic odd);
    logic [7:0] v;
    v = model_regs[model_index];
    if (!odd) return READ_EMPTY;
    if (model_index == IDX_ID0) return v & ID0_MASK;
    if (model_index == IDX_ID1) return v & ID1_MASK;
    if (model_index inside {IDX_ID0_B, IDX_ID0_C, [RIDX_SEG_CTL:IDX_LOW_LAST],
                            [IDX_HI_FIRST:IDX_HI_LAST]})
      return v;
    return READ_EMPTY;
  endfunction

  function automatic route_t route_for(input logic [19:0] addr, input logic wr);
    int         blk;
    int         seg;
    logic [7:0] map;
    if (addr < 20'h40000) return ROUTE_NONE;
    if (addr < 20'hC0000) begin
      blk = int'((addr - 20'h40000) >> 14) & 31;
      map = model_regs[RIDX_LOW_MAP + 8'(blk / 8)];
      return map[blk % 8] ? ROUTE_IO : ROUTE_BOARD;
    end
    blk = int'((addr - 20'hC0000) >> 14) & 15;
    map = model_regs[RIDX_HIGH_MAP + 8'(blk / 8)];
    if (map[blk % 8]) return ROUTE_IO;
    seg = blk / 4;
    map = model_regs[RIDX_SEG_CTL];
    return map[wr ? 7 - seg : 3 - seg] ? ROUTE_IO : ROUTE_BOARD;
  endfunction

  task automatic apply_beat(input beat_t b);
    answer_t a;
    a.read_data = '0;
    a.route     = ROUTE_BOARD;
    case (b.op)
      OP_WRITE: begin
        if (b.port_odd) model_regs[model_index] = b.data;
        else model_index = b.data;
      end
      OP_READ:  a.read_data = port_value(b.port_odd);
      OP_QUERY: a.route = route_for(b.address, b.access_write);
      default: ;
    endcase
    expected_answers.push_back(a);
  endtask

  task automatic push_beat(input logic [1:0] op, input logic odd, input logic [7:0] data,
                           input logic [19:0] addr, input logic wr);
    beat_t b;
    b.op           = op;
    b.port_odd     = odd;
    b.data         = data;
    b.address      = addr;
    b.access_write = wr;
    pending_beats.push_back(b);
  endtask

  function automatic logic [7:0] pick_index();
    logic [7:0] known[18];
    known = '{8'h04, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
              8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h28, 8'h29, 8'h2A};
    if ($urandom_range(0, 3) != 0) return known[$urandom_range(0, 17)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [19:0] pick_address();
    if ($urandom_range(0, 7) == 0) return 20'($urandom_range(0, 20'h3FFFF));
    return 20'($urandom_range(20'h40000, 20'hFFFFF));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      model_index = '0;
      foreach (model_regs[i]) model_regs[i] = '0;
    end else begin
      if (start && !busy) apply_beat(cur_beat);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat        = pending_beats.pop_front();
          in_op           <= cur_beat.op;
          in_port_odd     <= cur_beat.port_odd;
          in_data         <= cur_beat.data;
          in_address      <= cur_beat.address;
          in_access_write <= cur_beat.access_write;
          start           <= 1'b1;
          launched        = launched + 1;
          if (pending_beats.size() > TAIL_BEATS && ((launched / 64) % 2) == 0 &&
              $urandom_range(0, 3) == 0)
            gap_left <= $urandom_range(1, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_answers.size() == 0) begin
        $error("result strobe with no beat outstanding: read_data %0h route %0d",
               out_read_data, out_route);
        errors++;
      end else begin
        exp_a = expected_answers.pop_front();
        if (out_read_data !== exp_a.read_data) begin
          $error("read_data: expected %0h, got %0h", exp_a.read_data, out_read_data);
          errors++;
        end
        if (out_route !== exp_a.route) begin
          $error("route: expected %0d, got %0d", exp_a.route, out_route);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("index_data_regs_with_shadow_decode: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] idx;
    int         kind;
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_QUERY, 1'b1, 8'hFF, 20'h3FFFF, 1'b1);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'h40000, 1'b0);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'hFFFFF, 1'b1);
    push_beat(OP_READ,  1'b1, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_READ,  1'b0, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b0, IDX_ID0, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'hFF, 20'h00000, 1'b0);
    push_beat(OP_READ,  1'b1, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b0, IDX_ID1, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'hFF, 20'h00000, 1'b0);
    push_beat(OP_READ,  1'b1, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b0, RIDX_LOW_MAP, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'h01, 20'h00000, 1'b0);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'h40000, 1'b0);
    push_beat(OP_WRITE, 1'b0, RIDX_SEG_CTL, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'h81, 20'h00000, 1'b0);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'hC0000, 1'b1);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'hC0000, 1'b0);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'hF0000, 1'b0);
    push_beat(OP_WRITE, 1'b0, RIDX_HIGH_MAP + 8'h01, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'h80, 20'h00000, 1'b0);
    push_beat(OP_QUERY, 1'b0, 8'h00, 20'hFC000, 1'b0);
    push_beat(OP_WRITE, 1'b0, 8'hFF, 20'h00000, 1'b0);
    push_beat(OP_WRITE, 1'b1, 8'h55, 20'h00000, 1'b0);
    push_beat(OP_READ,  1'b1, 8'h00, 20'h00000, 1'b0);
    push_beat(OP_UNUSED, 1'b1, 8'hA5, 20'hFFFFF, 1'b1);

    while (pending_beats.size() < NUM_BEATS) begin
      kind = $urandom_range(0, 9);
      idx  = pick_index();
      if (kind < 4) begin
        push_beat(OP_WRITE, 1'b0, idx, pick_address(), 1'($urandom));
        push_beat(OP_WRITE, 1'b1, 8'($urandom), pick_address(), 1'($urandom));
      end else if (kind < 6) begin
        push_beat(OP_WRITE, 1'b0, idx, pick_address(), 1'($urandom));
        push_beat(OP_READ, 1'b1, 8'($urandom), pick_address(), 1'($urandom));
      end else if (kind < 9) begin
        push_beat(OP_QUERY, 1'($urandom), 8'($urandom), pick_address(), 1'($urandom));
      end else begin
        push_beat(2'($urandom_range(0, 2)), 1'($urandom), 8'($urandom),
                  20'($urandom), 1'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_beats.size() != 0 || gap_left != 0 || start);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("index_data_regs_with_shadow_decode: match");
    end else begin
      $display("index_data_regs_with_shadow_decode: mismatch");
    end
    $finish;
  end

endmodule
